// ===== hw/rtl/rfp_pkg.sv =====
// Shared types and constants for the rangefinder frame parser.
`timescale 1ns / 1ps

package rfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FRAME_LEN  = 8;
  localparam int unsigned WIN_DEPTH  = FRAME_LEN - 1;   // bytes held between transactions
  localparam int unsigned FILL_W     = 3;               // holds 0..WIN_DEPTH
  localparam int unsigned SENSOR_BIT = 7;
  localparam int unsigned RANGE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hB4;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h69;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SENSOR   = 2'd1,
    STATUS_CHECKSUM = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t        status;
    logic [RANGE_W-1:0]   range_value;
  } frame_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
  } sync_cfg_t;

endpackage

// ===== hw/rtl/rfp_window.sv =====
// Byte window, header match and frame decode.
`timescale 1ns / 1ps

module rfp_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_fire,
  input  logic [rfp_pkg::BYTE_W-1:0]    rx_byte,
  input  rfp_pkg::sync_cfg_t            sync_cfg,
  output logic                          res_valid,
  output rfp_pkg::frame_result_t        res
);

  logic [rfp_pkg::BYTE_W-1:0] win_r   [rfp_pkg::WIN_DEPTH];
  logic [rfp_pkg::BYTE_W-1:0] win_nxt [rfp_pkg::WIN_DEPTH];
  logic [rfp_pkg::BYTE_W-1:0] frame   [rfp_pkg::FRAME_LEN];
  logic [rfp_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [rfp_pkg::BYTE_W-1:0] chk;
  logic                       full, hdr_ok;

  // Candidate frame: held bytes plus the incoming one.
  always_comb begin
    for (int i = 0; i < int'(rfp_pkg::WIN_DEPTH); i++) begin
      frame[i] = win_r[i];
    end
    frame[rfp_pkg::FRAME_LEN-1] = rx_byte;
  end

  assign full   = (fill_r == rfp_pkg::FILL_W'(rfp_pkg::WIN_DEPTH));
  assign hdr_ok = (frame[0] == sync_cfg.first) && (frame[1] == sync_cfg.second);

  always_comb begin
    chk = '0;
    for (int i = 0; i < int'(rfp_pkg::WIN_DEPTH); i++) begin
      chk = chk ^ frame[i];
    end
  end

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (byte_fire) begin
      if (!full) begin
        for (int i = 0; i < int'(rfp_pkg::WIN_DEPTH); i++) begin
          if (fill_r == rfp_pkg::FILL_W'(i)) begin
            win_nxt[i] = rx_byte;
          end
        end
        fill_nxt = fill_r + 1'b1;
      end else if (hdr_ok) begin
        fill_nxt = '0;
      end else begin
        // resync: drop oldest, keep seven
        for (int i = 0; i < int'(rfp_pkg::WIN_DEPTH); i++) begin
          win_nxt[i] = frame[i+1];
        end
      end
    end
  end

  assign res_valid = byte_fire && full && hdr_ok;

  always_comb begin
    if (chk != frame[rfp_pkg::FRAME_LEN-1]) begin
      res.status      = rfp_pkg::STATUS_CHECKSUM;
      res.range_value = '0;
    end else if (frame[2][rfp_pkg::SENSOR_BIT]) begin
      res.status      = rfp_pkg::STATUS_SENSOR;
      res.range_value = '0;
    end else begin
      res.status      = rfp_pkg::STATUS_OK;
      res.range_value = {frame[3], frame[4], frame[5], frame[6]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

// ===== hw/rtl/rfp_out_buf.sv =====
// Result register with skid stage.
`timescale 1ns / 1ps

module rfp_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  rfp_pkg::frame_result_t res,
  input  logic                   out_stall,
  output logic                   out_valid,
  output rfp_pkg::frame_result_t out_res,
  output logic                   skid_full
);

  logic                   out_valid_r, out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  rfp_pkg::frame_result_t out_r, out_nxt;
  rfp_pkg::frame_result_t skid_r, skid_nxt;
  logic                   out_fire;

  assign out_fire = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign skid_full = skid_valid_r;

endmodule

// ===== hw/rtl/rangefinder_frame_parser_top.sv =====
// Top level of the rangefinder frame parser.
`timescale 1ns / 1ps
//
// Usage:
// - Input channel (in_valid / in_stall / in_rx_byte): one received serial byte
//   per transaction. Bytes collect in a seven-byte window; the eighth byte
//   completes a candidate frame that is checked against the sync bytes.
// - Header mismatch: oldest byte is dropped, no result. Header match: all
//   eight bytes are consumed and one result transaction is produced.
// - Result channel (out_valid / out_stall / out_frame_status / out_range_value):
//   status OK with big-endian distance from bytes 3..6, sensor error (byte 2
//   bit 7), or checksum error (XOR of bytes 0..6 != byte 7, checked first).
// - Result path: the result is registered, in the skid stage if the output is held.
// - Throughput: one byte per cycle unless stalled; single compare/shift update.
// - Receiver stall: result register plus a one-entry skid stage. in_stall is
//   raised only while the skid holds a result, so input keeps flowing while
//   a single result waits.
// - Reset (rst_n low, synchronous): empty window, empty output, sync bytes
//   back to 0xB4 / 0x69.
// - cfg_we writes cfg_wdata to register cfg_index (0 first sync byte,
//   1 second); other indexes are ignored. Write only while idle.

module rangefinder_frame_parser_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rfp_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rfp_pkg::STATUS_W-1:0]     out_frame_status,
  output logic [rfp_pkg::RANGE_W-1:0]      out_range_value,
  input  logic                             cfg_we,
  input  logic [rfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfp_pkg::BYTE_W-1:0]       cfg_wdata
);

  rfp_pkg::sync_cfg_t     sync_r, sync_nxt;
  rfp_pkg::frame_result_t res, out_res;
  logic                   in_fire, res_valid, skid_full;

  // Config registers
  always_comb begin
    sync_nxt = sync_r;
    if (cfg_we) begin
      case (cfg_index)
        rfp_pkg::CFG_SYNC_FIRST:  sync_nxt.first  = cfg_wdata;
        rfp_pkg::CFG_SYNC_SECOND: sync_nxt.second = cfg_wdata;
        default:                  sync_nxt        = sync_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r.first  <= rfp_pkg::SYNC_FIRST_RST;
      sync_r.second <= rfp_pkg::SYNC_SECOND_RST;
    end else begin
      sync_r <= sync_nxt;
    end
  end

  assign in_stall = skid_full;
  assign in_fire  = in_valid && !in_stall;

  rfp_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .rx_byte   (in_rx_byte),
    .sync_cfg  (sync_r),
    .res_valid (res_valid),
    .res       (res)
  );

  rfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .skid_full (skid_full)
  );

  assign out_frame_status = out_res.status;
  assign out_range_value  = out_res.range_value;

  // Skid only fills behind an occupied result register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid holds a result while output register is empty");

  // Error results never carry a distance.
  a_err_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_frame_status != rfp_pkg::STATUS_OK)) |-> (out_range_value == '0))
    else $error("error status with nonzero range");

  // A new result only follows an accepted byte.
  a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an input transaction");

endmodule
